// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent must hold in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/ihp_pkg.sv
// Shared types, constants and the hex digit decoder of the hex record parser.
package ihp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_OK     = 2'd1,
        KIND_CKERR  = 2'd2,
        KIND_FMTERR = 2'd3
    } result_kind_t;

    typedef struct packed {
        logic [7:0]   record_length;
        logic [15:0]  record_address;
        logic [7:0]   record_type;
        logic [7:0]   byte_index;
        logic [7:0]   data_byte;
        result_kind_t result_kind;
    } result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Decodes one ASCII character as a hex digit, either case.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d.value = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            d.value = 4'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            d.value = 4'(c - 8'h57);
        end
        else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: rtl/core/ihp_front.sv
// Front part: accepts characters, tracks the record phase and forms result items.
module ihp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  ihp_pkg::q_stat_t q_stat,
    output logic             push,
    output ihp_pkg::result_t push_data
);
    import ihp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_ADDR = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4,
        PH_CKS  = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  nib_reg, nib_next;
    logic [15:0] partial_reg, partial_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seen_reg, seen_next;

    logic        accept;
    hex_digit_t  digit;
    logic [15:0] pv;
    logic [7:0]  b;
    logic        field_done;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign digit    = hex_decode(s_tdata);
    assign pv       = {partial_reg[11:0], digit.value};
    assign b        = pv[7:0];
    assign field_done = (phase_reg == PH_ADDR) ? (nib_reg == 2'd3) : (nib_reg == 2'd1);

    always_comb
    begin
        phase_next   = phase_reg;
        nib_next     = nib_reg;
        partial_next = partial_reg;
        sum_next     = sum_reg;
        len_next     = len_reg;
        addr_next    = addr_reg;
        type_next    = type_reg;
        seen_next    = seen_reg;
        push         = 1'b0;
        push_data.result_kind    = KIND_FMTERR;
        push_data.data_byte      = 8'd0;
        push_data.byte_index     = 8'd0;
        push_data.record_type    = type_reg;
        push_data.record_address = addr_reg;
        push_data.record_length  = len_reg;

        if (accept) begin
            if (phase_reg == PH_IDLE) begin
                if (s_tdata == CHAR_COLON) begin
                    phase_next   = PH_LEN;
                    nib_next     = 2'd0;
                    partial_next = 16'd0;
                    sum_next     = 8'd0;
                    len_next     = 8'd0;
                    addr_next    = 16'd0;
                    type_next    = 8'd0;
                    seen_next    = 8'd0;
                end
            end
            else if (s_tdata == CHAR_COLON) begin
                // Report the broken record, then start the new one at once.
                push         = 1'b1;
                phase_next   = PH_LEN;
                nib_next     = 2'd0;
                partial_next = 16'd0;
                sum_next     = 8'd0;
                len_next     = 8'd0;
                addr_next    = 16'd0;
                type_next    = 8'd0;
                seen_next    = 8'd0;
            end
            else if (!digit.valid) begin
                push         = 1'b1;
                phase_next   = PH_IDLE;
                nib_next     = 2'd0;
                partial_next = 16'd0;
            end
            else if (!field_done) begin
                nib_next     = nib_reg + 2'd1;
                partial_next = pv;
            end
            else begin
                nib_next     = 2'd0;
                partial_next = 16'd0;
                case (phase_reg)
                    PH_LEN:
                    begin
                        len_next   = b;
                        sum_next   = sum_reg + b;
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        addr_next  = pv;
                        sum_next   = sum_reg + pv[15:8] + b;
                        phase_next = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        type_next  = b;
                        sum_next   = sum_reg + b;
                        phase_next = (len_reg == 8'd0) ? PH_CKS : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        push                  = 1'b1;
                        push_data.result_kind = KIND_DATA;
                        push_data.data_byte   = b;
                        push_data.byte_index  = seen_reg;
                        sum_next   = sum_reg + b;
                        seen_next  = seen_reg + 8'd1;
                        phase_next = (seen_reg + 8'd1 == len_reg) ? PH_CKS : PH_DATA;
                    end
                    default:
                    begin
                        push                  = 1'b1;
                        sum_next              = sum_reg + b;
                        push_data.result_kind = (sum_next == 8'd0) ? KIND_OK : KIND_CKERR;
                        phase_next            = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            nib_reg     <= 2'd0;
            partial_reg <= 16'd0;
            sum_reg     <= 8'd0;
            len_reg     <= 8'd0;
            addr_reg    <= 16'd0;
            type_reg    <= 8'd0;
            seen_reg    <= 8'd0;
        end
        else begin
            phase_reg   <= phase_next;
            nib_reg     <= nib_next;
            partial_reg <= partial_next;
            sum_reg     <= sum_next;
            len_reg     <= len_next;
            addr_reg    <= addr_next;
            type_reg    <= type_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

// File: rtl/core/ihp_queue.sv
// Short result queue between the parser front and the output stage.
module ihp_queue #(
    parameter int DEPTH = ihp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ihp_pkg::result_t push_data,
    input  logic             pop,
    output ihp_pkg::result_t head,
    output ihp_pkg::q_stat_t q_stat
);
    import ihp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t              mem [DEPTH];
    logic [PTR_W-1:0]     wr_reg, wr_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;
    assign head    = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/ihp_back.sv
// Back part: output register that drains the queue onto the master stream.
module ihp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ihp_pkg::q_stat_t q_stat,
    input  ihp_pkg::result_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser
);
    import ihp_pkg::*;

    logic    valid_reg, valid_next;
    result_t out_reg;

    assign pop        = !q_stat.empty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            out_reg <= head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {out_reg.record_length, out_reg.record_address,
                       out_reg.record_type, out_reg.byte_index, out_reg.data_byte};

endmodule

// File: rtl/core/ihex_record_parser.sv
// Top level of the Intel HEX record parser: front, result queue and output stage.
//
// The slave stream carries one ASCII character per beat in s_tdata. A ':'
// opens a record; length, address, type, data and checksum follow as hex
// digit pairs in either case. The master stream carries one result per beat:
// m_tuser holds the result kind (data byte, record ok, checksum error or
// format error) and m_tdata holds data byte, byte index, record type, record
// address and record length. Characters that produce no result, such as
// line endings between records, are consumed silently.
//
// Throughput is one character per cycle while the result queue is not full;
// the parser step is a nibble decode and an 8-bit add. A result is written
// into the queue when its character is accepted, and from there moves
// into the output register that drives the master side.
//
// Reset puts the parser in its idle phase, waiting for a colon, and empties
// the queue and the output register. When the receiver stalls, results
// collect in the queue; once it is full, s_tready drops for every character,
// including ones that would produce no result, until a beat is taken.
module ihex_record_parser #(
    parameter int QUEUE_DEPTH = ihp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ascii_char
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] record_type,
    // [39:24] record_address, [47:40] record_length
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] result_kind
);
    import ihp_pkg::*;

    q_stat_t q_stat;
    logic    push;
    result_t push_data;
    logic    pop;
    result_t head;

    // The front parses each accepted character and pushes at most one result.
    ihp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // The queue lets the parser keep running while the receiver stalls.
    ihp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // The back stage presents the head of the queue as a registered beat.
    ihp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/core/ihp_checker.sv
// Port-level checker for the hex record parser and its bind statement.
`include "assert_macros.svh"

module ihp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ihp_pkg::*;

    logic stalled;
    logic is_data;
    logic in_beat;

    assign stalled = m_tvalid && !m_tready;
    assign is_data = m_tvalid && (m_tuser == KIND_DATA);
    assign in_beat = s_tvalid && s_tready;

    // A stalled result beat holds its payload.
    `ASSERT_NEXT(a_hold, clk, rst_n, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Record results carry neither a data byte nor an index.
    `ASSERT_SAME(a_zero_fields, clk, rst_n, m_tvalid && !is_data, m_tdata[15:0] == 16'd0)

    // A data byte always lies inside the record's byte count.
    `ASSERT_SAME(a_index_range, clk, rst_n, is_data, m_tdata[15:8] < m_tdata[47:40])

    // An accepted character is always a defined value.
    `ASSERT_SAME(a_in_known, clk, rst_n, in_beat, !$isunknown(s_tdata))

    // A result beat never shows undefined payload bits.
    `ASSERT_SAME(a_out_known, clk, rst_n, m_tvalid, !$isunknown({m_tdata, m_tuser}))

endmodule

bind ihex_record_parser ihp_checker u_ihp_checker (.*);

// File: verif/ihex_checker.sv
// Checker for the hex record parser: predicts every result beat and compares it field by field.
module ihex_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          data_beats,
    output int          ok_beats,
    output int          cksum_beats,
    output int          format_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    import ihp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_ADDRESS,
        PH_TYPE,
        PH_DATA,
        PH_CHECKSUM
    } phase_t;

    phase_t      phase      = PH_IDLE;
    logic [2:0]  digits     = '0;
    logic [15:0] partial    = '0;
    logic [7:0]  sum        = '0;
    logic [7:0]  held_len   = '0;
    logic [15:0] held_addr  = '0;
    logic [7:0]  held_type  = '0;
    logic [7:0]  byte_count = '0;

    result_t     expected_results[$];
    int          errors = 0;
    int          seen_kind[4] = '{0, 0, 0, 0};

    // Bit 4 of the return value flags a valid hex digit, either case.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function automatic void open_record();
        phase      = PH_LENGTH;
        digits     = '0;
        partial    = '0;
        sum        = '0;
        held_len   = '0;
        held_addr  = '0;
        held_type  = '0;
        byte_count = '0;
    endfunction

    function automatic void next_field(input phase_t p);
        phase   = p;
        digits  = '0;
        partial = '0;
    endfunction

    function automatic result_t make_result(input result_kind_t kind, input logic [7:0] value,
                                            input logic [7:0] index);
        result_t r;
        r.result_kind    = kind;
        r.data_byte      = value;
        r.byte_index     = index;
        r.record_type    = held_type;
        r.record_address = held_addr;
        r.record_length  = held_len;
        return r;
    endfunction

    // Advances the parser by one character; returns 1 when a result beat is due.
    function automatic bit parse_char(input logic [7:0] c, output result_t res);
        logic [4:0] nib;
        logic [7:0] b;
        res = '0;
        if (phase == PH_IDLE) begin
            if (c == CHAR_COLON) begin
                open_record();
            end
            return 1'b0;
        end
        if (c == CHAR_COLON) begin
            res = make_result(KIND_FMTERR, 8'd0, 8'd0);
            open_record();
            return 1'b1;
        end
        nib = hex_nibble(c);
        if (!nib[4]) begin
            res = make_result(KIND_FMTERR, 8'd0, 8'd0);
            next_field(PH_IDLE);
            return 1'b1;
        end
        partial = {partial[11:0], nib[3:0]};
        digits  = digits + 3'd1;
        if (digits != ((phase == PH_ADDRESS) ? 3'd4 : 3'd2)) begin
            return 1'b0;
        end
        b = partial[7:0];
        case (phase)
            PH_LENGTH:
            begin
                held_len = b;
                sum      = sum + b;
                next_field(PH_ADDRESS);
            end
            PH_ADDRESS:
            begin
                held_addr = partial;
                sum       = sum + partial[15:8] + b;
                next_field(PH_TYPE);
            end
            PH_TYPE:
            begin
                held_type = b;
                sum       = sum + b;
                next_field((held_len == 8'd0) ? PH_CHECKSUM : PH_DATA);
            end
            PH_DATA:
            begin
                res        = make_result(KIND_DATA, b, byte_count);
                sum        = sum + b;
                byte_count = byte_count + 8'd1;
                next_field((byte_count == held_len) ? PH_CHECKSUM : PH_DATA);
                return 1'b1;
            end
            default:
            begin
                sum = sum + b;
                res = make_result((sum == 8'd0) ? KIND_OK : KIND_CKERR, 8'd0, 8'd0);
                next_field(PH_IDLE);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Inputs and outputs are sampled at the clock edge, before the block updates.
    always @(posedge clk or negedge rst_n) begin : monitor
        result_t r;
        result_t want;
        if (!rst_n) begin
            open_record();
            phase = PH_IDLE;
            expected_results.delete();
            pending <= 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                if (parse_char(s_tdata, r)) begin
                    expected_results.push_back(r);
                end
            end
            if (m_tvalid && m_tready) begin
                seen_kind[m_tuser]++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result beat, expected none, actual kind %0d tdata 0x%h",
                             $time, m_tuser, m_tdata);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 16'(want.result_kind), 16'(m_tuser));
                    check_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
                    check_field("byte_index", 16'(want.byte_index), 16'(m_tdata[15:8]));
                    check_field("record_type", 16'(want.record_type), 16'(m_tdata[23:16]));
                    check_field("record_address", want.record_address, m_tdata[39:24]);
                    check_field("record_length", 16'(want.record_length), 16'(m_tdata[47:40]));
                end
            end
            pending <= expected_results.size();
        end
        fail_count   <= errors;
        data_beats   <= seen_kind[KIND_DATA];
        ok_beats     <= seen_kind[KIND_OK];
        cksum_beats  <= seen_kind[KIND_CKERR];
        format_beats <= seen_kind[KIND_FMTERR];
    end

endmodule

// File: verif/tb.sv
// Testbench top for the hex record parser: clock, reset, character stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihp_pkg::*;

    // Characters used by the stimulus beside the colon from the package.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_G     = 8'h47;

    localparam int CHAR_TARGET = 1350;
    localparam int HOLD_CYCLES = 120;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int data_beats;
    int ok_beats;
    int cksum_beats;
    int format_beats;

    // Characters accepted so far, and records started by the random part.
    int chars_sent   = 0;
    int records_sent = 0;

    // While steady is set neither side inserts idle cycles.
    bit steady = 1'b0;

    // The sender asks for a long receiver hold-off by bumping holds_asked;
    // the receiver serves each request in its own process.
    int holds_asked  = 0;
    int holds_served = 0;

    // Characters of the record under construction.
    logic [7:0] line_chars[$];

    ihex_record_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ihex_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .data_beats   (data_beats),
        .ok_beats     (ok_beats),
        .cksum_beats  (cksum_beats),
        .format_beats (format_beats)
    );

    always #6 clk = ~clk;

    // Turns a nibble into an ASCII hex digit; letters come in random case.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return (($urandom_range(1) == 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_hex(input logic [7:0] b);
        line_chars.push_back(hex_digit(b[7:4]));
        line_chars.push_back(hex_digit(b[3:0]));
    endfunction

    // Builds one complete record; with bad_sum set the checksum is random
    // and so is wrong most of the time.
    task automatic build_record(input int len, input logic [15:0] addr,
                                input logic [7:0] rtype, input bit bad_sum);
        logic [7:0] total;
        logic [7:0] b;
        line_chars.delete();
        line_chars.push_back(CHAR_COLON);
        push_hex(8'(len));
        push_hex(addr[15:8]);
        push_hex(addr[7:0]);
        push_hex(rtype);
        total = 8'(len) + addr[15:8] + addr[7:0] + rtype;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            push_hex(b);
            total = total + b;
        end
        push_hex(bad_sum ? 8'($urandom) : 8'(-total));
    endtask

    // Offers one character and holds it until the beat is taken. Gaps come
    // before the beat, so they land on every phase of the parser.
    task automatic send_char(input logic [7:0] c);
        while (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        chars_sent++;
        steady = (chars_sent >= 450 && chars_sent < 650);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_prefix(input int n);
        for (int i = 0; i < n; i++) begin
            send_char(line_chars[i]);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is asked.
    initial begin : receiver
        int cycles;
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                m_tready <= 1'b0;
                for (cycles = 0; cycles < HOLD_CYCLES; cycles++) begin
                    @(posedge clk);
                end
            end
            else begin
                m_tready <= steady || ($urandom_range(99) >= 26);
                @(posedge clk);
            end
        end
    end

    // A run that hangs ends here.
    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d results still expected", pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int  pick;
        int  len;
        int  cut;
        bit  late_hold = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An end-of-file record with a good checksum; a colon
        // inside a record, which reports a format error and restarts; a record
        // with address, type and data at their maxima in mixed case; a line ending
        // between records; a non-hex digit inside a record; and a stray character while idle.
        send_text(":00000001FF");
        send_text(":0:01ffFFffFF05");
        send_char(CH_LF);
        send_text(":1G");
        send_char(8'h00);

        // The first random record is the longest the byte count allows; the
        // receiver holds off meanwhile, so the result queue fills and the
        // parser stalls its input.
        holds_asked++;
        build_record(255, 16'($urandom), 8'h00, 1'b0);
        send_prefix(line_chars.size());
        records_sent++;

        while (chars_sent < CHAR_TARGET) begin
            if (!late_hold && chars_sent >= 900) begin
                late_hold = 1'b1;
                holds_asked++;
            end
            pick = $urandom_range(99);
            len  = ($urandom_range(79) == 0) ? $urandom_range(255, 9) : $urandom_range(8);
            build_record(len, 16'($urandom),
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5)),
                         $urandom_range(4) == 0);
            if (pick < 72) begin
                // Well-formed record followed by one of the usual line endings.
                send_prefix(line_chars.size());
                records_sent++;
                case ($urandom_range(2))
                    1: send_char(CH_LF);
                    2:
                    begin
                        send_char(CH_CR);
                        send_char(CH_LF);
                    end
                    default: ;
                endcase
            end
            else if (pick < 88) begin
                // Record broken off at a random point by a colon, whitespace,
                // a non-hex letter or an arbitrary byte.
                cut = $urandom_range(line_chars.size() - 1, 1);
                send_prefix(cut);
                records_sent++;
                case ($urandom_range(3))
                    0: send_char(CHAR_COLON);
                    1: send_char(($urandom_range(1) == 0) ? CH_SPACE : CH_CR);
                    2: send_char(CH_G);
                    default: send_char(8'($urandom));
                endcase
            end
            else begin
                // Noise between records, any byte value.
                repeat ($urandom_range(4, 1)) begin
                    send_char(8'($urandom));
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every expected beat, then wait longer so
        // that any extra beat would still be seen.
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d records plus noise.", chars_sent, records_sent);
        $display("Checked %0d data bytes, %0d good records, %0d checksum and %0d format errors.",
                 data_beats, ok_beats, cksum_beats, format_beats);
        if (pending != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end
        else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: ihex_record_parser.f
+incdir+rtl/core
rtl/core/ihp_pkg.sv
rtl/core/ihp_front.sv
rtl/core/ihp_queue.sv
rtl/core/ihp_back.sv
rtl/core/ihex_record_parser.sv
rtl/core/ihp_checker.sv
verif/ihex_checker.sv
verif/tb.sv
